[rtl/nbc_pkg.sv]
`default_nettype none
package nbc_pkg;

	// capacity and field widths
	localparam int MAX_RECORDS = 1024;
	localparam int AGE_W       = 11;
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int SUM_W       = CNT_W + AGE_W;
	localparam int SQ_W        = CNT_W + 2 * AGE_W;
	localparam int D_W         = CNT_W + SQ_W;
	localparam int DEV2_W      = 2 * SUM_W;

	// deviation quotient: num = dev^2 * (n-1) << 16, den = 2n * D
	localparam int QF_W        = 16;
	localparam int NUMH_W      = DEV2_W + CNT_W;
	localparam int NUM_W       = NUMH_W + QF_W;
	localparam int DEN_W       = CNT_W + 1 + D_W;
	localparam int T_W         = 56;

	// logarithm unit
	localparam int MANT_W      = 31;
	localparam int FRAC_W      = 24;
	localparam int LX_W        = (D_W > MANT_W) ? D_W : MANT_W;
	localparam int K_W         = $clog2(LX_W);
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam int LN_SHIFT    = 40;

	// shared multiplier
	localparam int MA_W        = (D_W > MANT_W) ? D_W : MANT_W;
	localparam int MB_W        = (SUM_W > 32) ? SUM_W : 32;
	localparam int P_W         = MA_W + MB_W;
	localparam int LN_W        = P_W - LN_SHIFT;

	// score accumulator
	localparam int SC_W        = ((T_W > LN_W) ? T_W : LN_W) + 4;

	typedef enum logic [1:0] {
		OP_TRAIN    = 2'd0,
		OP_CLASSIFY = 2'd1
	} nbc_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TR_MUL,
		ST_TR_UPD,
		ST_RD_NQ,
		ST_RD_SS,
		ST_RD_D,
		ST_CHECK,
		ST_SC_NA,
		ST_SC_DEV,
		ST_SC_DSQ,
		ST_SC_NUM,
		ST_SC_DEN,
		ST_SC_DIV,
		ST_LOG_LOAD,
		ST_LOG_NORM,
		ST_LOG_SQM,
		ST_LOG_SQU,
		ST_LOG_MULK,
		ST_LOG_ACC,
		ST_SC_TWAIT,
		ST_SC_NEXT,
		ST_OUT
	} nbc_state_t;

	// log operand selection
	typedef enum logic [2:0] {
		LS_TRAVEL = 3'd0,
		LS_SEX    = 3'd1,
		LS_N      = 3'd2,
		LS_NM1    = 3'd3,
		LS_D      = 3'd4
	} nbc_lsel_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   num;
		logic [DEN_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic [T_W-1:0]     quo;
	} div_sts_t;

endpackage
`default_nettype wire

[rtl/nbc_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle, saturating at 2^T_W-1
module nbc_div import nbc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_sts_t      sts
);

	localparam int DC_W     = $clog2(NUM_W);
	localparam int HI_STEPS = (NUM_W > T_W) ? (NUM_W - T_W) : 0;

	logic               busy_q;
	logic [DC_W-1:0]    cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [T_W-1:0]     quo_q;
	logic               sat_q;

	logic [DEN_W:0]     shifted;
	logic [DEN_W:0]     diff;
	logic               ge;

	// one trial subtraction
	always_comb begin
		shifted = {rem_q, num_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			sat_q  <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			sat_q  <= 1'b0;
		end else if (busy_q) begin
			if (ge && (int'(cnt_q) < HI_STEPS))
				sat_q <= 1'b1;
			if (cnt_q == DC_W'(NUM_W - 1))
				busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[T_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.quo  = sat_q ? {T_W{1'b1}} : quo_q;

endmodule
`default_nettype wire

[rtl/naive_bayes_classifier.sv]
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid/in_ready    opcode, travel_class, sex, age, label
// out       out_valid/out_ready  predicted, incomplete
//
// A training request returns nothing. A classify request skips scoring when
// a class is not yet trained; otherwise it is paced by the single shared
// multiplier: per class five logarithms, each a normalising shift followed
// by 24 squarings. The divider runs alongside.
// in_ready is high only while idle. A finished result waits in the output
// register; a new request is taken meanwhile, and a later result stalls
// until that register is free. Reset clears all counts.
module naive_bayes_classifier import nbc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             opcode,
	input  wire logic [1:0]       travel_class,
	input  wire logic             sex,
	input  wire logic [AGE_W-1:0] age,
	input  wire logic             label,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  predicted,
	output logic                  incomplete
);

	nbc_state_t state_q, state_d;

	// latched request
	logic             op_q;
	logic [1:0]       t_q;
	logic             s_q;
	logic [AGE_W-1:0] a_q;
	logic             lab_q;

	// model counts
	logic [CNT_W-1:0] cnt_q  [2];
	logic [CNT_W-1:0] trav_q [6];
	logic [CNT_W-1:0] sexc_q [4];
	logic [SUM_W-1:0] sum_q  [2];
	logic [SQ_W-1:0]  sq_q   [2];

	// scoring registers
	logic             cls_q;
	logic [D_W-1:0]   d_q    [2];
	logic             rdy_q  [2];
	logic [D_W-1:0]   nq_q;
	logic [P_W-1:0]   prod_q;
	logic [SUM_W-1:0] dev_q;
	logic [NUMH_W-1:0] numh_q;
	logic [LX_W-1:0]  lx_q;
	logic [K_W-1:0]   lk_q;
	logic [MANT_W-1:0] lm_q;
	logic [FRAC_W-1:0] lf_q;
	logic [4:0]       lstep_q;
	nbc_lsel_t        lsel_q;
	logic signed [SC_W-1:0] score_q, score0_q;
	logic             fin0_q;
	logic             pend_pred_q, pend_inc_q;
	logic             outv_q, pred_q, inc_q;

	// combinational
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [CNT_W-1:0] n_c, ct_c, cs_c;
	logic [SUM_W-1:0] na;
	logic             fin_c;
	logic [LX_W-1:0]  lop;
	logic [P_W-1:0]   lsum;
	logic signed [SC_W-1:0] ln_ext, t_ext;
	logic [MANT_W:0]  msq;
	logic [CNT_W:0]   total;
	logic             accept_in;
	logic             out_free;
	div_req_t         div_req;
	div_sts_t         div_sts;

	nbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	// selected class operands
	always_comb begin
		n_c  = cnt_q[cls_q];
		cs_c = sexc_q[{cls_q, s_q}];
		if (t_q == 2'd0)
			ct_c = '0;
		else
			ct_c = trav_q[3'(cls_q) * 3'd3 + 3'(t_q) - 3'd1];
		fin_c = (ct_c != '0) && (cs_c != '0);
		na    = prod_q[SUM_W-1:0];
		total = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		msq   = prod_q[2*MANT_W-1:MANT_W-1];
		lsum  = prod_q + (P_W'(1) << (LN_SHIFT - 1));
		ln_ext = $signed({{(SC_W-LN_W){1'b0}}, lsum[P_W-1:LN_SHIFT]});
		t_ext  = $signed({{(SC_W-T_W){1'b0}}, div_sts.quo});
	end

	// log operand
	always_comb begin
		case (lsel_q)
			LS_TRAVEL: lop = LX_W'(ct_c);
			LS_SEX:    lop = LX_W'(cs_c);
			LS_N:      lop = LX_W'(n_c);
			LS_NM1:    lop = LX_W'(n_c - 1'b1);
			LS_D:      lop = LX_W'(d_q[cls_q]);
			default:   lop = LX_W'(d_q[cls_q]);
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TR_MUL: begin
				mul_a = MA_W'(a_q);
				mul_b = MB_W'(a_q);
			end
			ST_RD_NQ: begin
				mul_a = MA_W'(sq_q[cls_q]);
				mul_b = MB_W'(n_c);
			end
			ST_RD_SS: begin
				mul_a = MA_W'(sum_q[cls_q]);
				mul_b = MB_W'(sum_q[cls_q]);
			end
			ST_SC_NA: begin
				mul_a = MA_W'(a_q);
				mul_b = MB_W'(n_c);
			end
			ST_SC_DSQ: begin
				mul_a = MA_W'(dev_q);
				mul_b = MB_W'(dev_q);
			end
			ST_SC_NUM: begin
				mul_a = MA_W'(prod_q[DEV2_W-1:0]);
				mul_b = MB_W'(n_c - 1'b1);
			end
			ST_SC_DEN: begin
				mul_a = MA_W'(d_q[cls_q]);
				mul_b = MB_W'({n_c, 1'b0});
			end
			ST_LOG_SQM: begin
				mul_a = MA_W'(lm_q);
				mul_b = MB_W'(lm_q);
			end
			ST_LOG_MULK: begin
				mul_a = MA_W'({lk_q, lf_q});
				mul_b = MB_W'(LN2_Q32);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_valid)
					state_d = (nbc_op_t'({1'b0, opcode}) == OP_CLASSIFY) ? ST_RD_NQ : ST_TR_MUL;
			ST_TR_MUL:   state_d = ST_TR_UPD;
			ST_TR_UPD:   state_d = ST_IDLE;
			ST_RD_NQ:    state_d = ST_RD_SS;
			ST_RD_SS:    state_d = ST_RD_D;
			ST_RD_D:     state_d = cls_q ? ST_CHECK : ST_RD_NQ;
			ST_CHECK:    state_d = (rdy_q[0] && rdy_q[1]) ? ST_SC_NA : ST_OUT;
			ST_SC_NA:    state_d = ST_SC_DEV;
			ST_SC_DEV:   state_d = ST_SC_DSQ;
			ST_SC_DSQ:   state_d = ST_SC_NUM;
			ST_SC_NUM:   state_d = ST_SC_DEN;
			ST_SC_DEN:   state_d = ST_SC_DIV;
			ST_SC_DIV:   state_d = ST_LOG_LOAD;
			ST_LOG_LOAD: state_d = ST_LOG_NORM;
			ST_LOG_NORM:
				if (lx_q[LX_W-1])
					state_d = ST_LOG_SQM;
			ST_LOG_SQM:  state_d = ST_LOG_SQU;
			ST_LOG_SQU:
				state_d = (lstep_q == 5'(FRAC_W - 1)) ? ST_LOG_MULK : ST_LOG_SQM;
			ST_LOG_MULK: state_d = ST_LOG_ACC;
			ST_LOG_ACC:  state_d = (lsel_q == LS_D) ? ST_SC_TWAIT : ST_LOG_LOAD;
			ST_SC_TWAIT:
				if (!div_sts.busy)
					state_d = ST_SC_NEXT;
			ST_SC_NEXT:  state_d = cls_q ? ST_OUT : ST_SC_NA;
			ST_OUT:
				if (out_free)
					state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// handshake and divider control
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		accept_in     = in_valid && in_ready;
		out_free      = !outv_q || out_ready;
		div_req.start = (state_q == ST_SC_DIV);
		div_req.num   = {numh_q, {QF_W{1'b0}}};
		div_req.den   = prod_q[DEN_W-1:0];
		out_valid     = outv_q;
		predicted     = pred_q;
		incomplete    = inc_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			outv_q  <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
			for (int i = 0; i < 6; i++)
				trav_q[i] <= '0;
			for (int i = 0; i < 4; i++)
				sexc_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free)
				outv_q <= 1'b1;
			else if (out_ready)
				outv_q <= 1'b0;
			// training update, dropped past capacity or for travel class zero
			if (state_q == ST_TR_UPD && t_q != 2'd0 && total < (CNT_W+1)'(MAX_RECORDS)) begin
				cnt_q[lab_q] <= cnt_q[lab_q] + 1'b1;
				trav_q[3'(lab_q) * 3'd3 + 3'(t_q) - 3'd1] <=
					trav_q[3'(lab_q) * 3'd3 + 3'(t_q) - 3'd1] + 1'b1;
				sexc_q[{lab_q, s_q}] <= sexc_q[{lab_q, s_q}] + 1'b1;
				sum_q[lab_q] <= sum_q[lab_q] + SUM_W'(a_q);
				sq_q[lab_q]  <= sq_q[lab_q] + SQ_W'(prod_q[2*AGE_W-1:0]);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_OUT && out_free) begin
			pred_q <= pend_pred_q;
			inc_q  <= pend_inc_q;
		end
		case (state_q)
			ST_IDLE:
				if (accept_in) begin
					op_q  <= opcode;
					t_q   <= travel_class;
					s_q   <= sex;
					a_q   <= age;
					lab_q <= label;
					cls_q <= 1'b0;
				end
			ST_RD_SS:
				nq_q <= prod_q[D_W-1:0];
			ST_RD_D: begin
				d_q[cls_q]   <= (nq_q > prod_q[D_W-1:0]) ? nq_q - prod_q[D_W-1:0] : '0;
				rdy_q[cls_q] <= (n_c >= CNT_W'(2)) && (nq_q > prod_q[D_W-1:0]);
				cls_q        <= 1'b1;
			end
			ST_CHECK: begin
				cls_q       <= 1'b0;
				score_q     <= '0;
				pend_pred_q <= 1'b0;
				pend_inc_q  <= !(rdy_q[0] && rdy_q[1]);
			end
			ST_SC_DEV:
				dev_q <= (na >= sum_q[cls_q]) ? na - sum_q[cls_q] : sum_q[cls_q] - na;
			ST_SC_DEN:
				numh_q <= prod_q[NUMH_W-1:0];
			ST_SC_DIV:
				lsel_q <= LS_TRAVEL;
			ST_LOG_LOAD: begin
				lx_q <= (lop == '0) ? LX_W'(1) : lop;
				lk_q <= K_W'(LX_W - 1);
			end
			ST_LOG_NORM:
				if (lx_q[LX_W-1]) begin
					lm_q    <= lx_q[LX_W-1 -: MANT_W];
					lf_q    <= '0;
					lstep_q <= '0;
				end else begin
					lx_q <= {lx_q[LX_W-2:0], 1'b0};
					lk_q <= lk_q - 1'b1;
				end
			ST_LOG_SQU: begin
				lm_q    <= msq[MANT_W] ? msq[MANT_W:1] : msq[MANT_W-1:0];
				lf_q    <= {lf_q[FRAC_W-2:0], msq[MANT_W]};
				lstep_q <= lstep_q + 1'b1;
			end
			ST_LOG_ACC: begin
				case (lsel_q)
					LS_TRAVEL, LS_SEX: score_q <= score_q + (ln_ext <<< 1);
					LS_NM1:            score_q <= score_q + ln_ext;
					default:           score_q <= score_q - ln_ext;
				endcase
				lsel_q <= nbc_lsel_t'(lsel_q + 3'd1);
			end
			ST_SC_TWAIT:
				if (!div_sts.busy)
					score_q <= score_q - (t_ext <<< 1);
			ST_SC_NEXT:
				if (!cls_q) begin
					score0_q <= score_q;
					fin0_q   <= fin_c;
					score_q  <= '0;
					cls_q    <= 1'b1;
				end else begin
					pend_pred_q <= fin_c && (!fin0_q || score_q >= score0_q) && op_q;
				end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[sim/tb_naive_bayes_classifier.sv]
`timescale 1ns / 1ps
module tb_naive_bayes_classifier;
	import nbc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam bit [63:0] DEV_CAP = (64'd1 << 56) - 64'd1;

	// Tracks class statistics and queues the expected classification of each request
	class nb_scoreboard;
		bit [63:0] n_cnt[2];
		bit [63:0] trav_cnt[6];
		bit [63:0] sex_cnt[4];
		bit [63:0] age_tot[2];
		bit [63:0] age_sq_tot[2];
		bit [1:0]  verdicts[$];	// {predicted, incomplete}

		function longint log_q16(bit [63:0] x);
			int k;
			bit [63:0] m;
			bit [63:0] frac;
			if (x == 0) x = 1;
			k = 63;
			while (k > 0 && !x[k]) k--;
			m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
			frac = 0;
			for (int i = 0; i < 24; i++) begin
				m = (m * m) >> 30;
				if (m >= 64'h8000_0000) begin
					m = m >> 1;
					frac[23 - i] = 1'b1;
				end
			end
			return longint'((((64'(k) << 24) | frac) * 64'(LN2_Q32) + (64'd1 << 39)) >> 40);
		endfunction

		function bit class_trained(int c);
			return n_cnt[c] >= 2 && n_cnt[c] * age_sq_tot[c] > age_tot[c] * age_tot[c];
		endfunction

		// doubled Q16 log score; fin cleared for a zero count
		function longint class_score(int c, bit [1:0] t, bit s, bit [63:0] a, output bit fin);
			bit [63:0] n, ct, cs, dsp, na, dev;
			bit [127:0] num, den, q;
			bit [63:0] dq;
			n   = n_cnt[c];
			ct  = (t != 0) ? trav_cnt[c * 3 + t - 1] : 0;
			cs  = sex_cnt[c * 2 + s];
			dsp = n * age_sq_tot[c] - age_tot[c] * age_tot[c];
			na  = n * a;
			dev = (na >= age_tot[c]) ? na - age_tot[c] : age_tot[c] - na;
			num = 128'(dev * dev) * 128'((n - 1) << 16);
			den = 128'(2 * n) * 128'(dsp);
			if (den == 0) dq = DEV_CAP;
			else begin
				q = num / den;
				dq = (q > 128'(DEV_CAP)) ? DEV_CAP : q[63:0];
			end
			fin = ct != 0 && cs != 0;
			if (!fin) return 0;
			return 2 * log_q16(ct) + 2 * log_q16(cs) - log_q16(n) + log_q16(n - 1)
				- log_q16(dsp) - 2 * longint'(dq);
		endfunction

		function void note_request(nbc_op_t op, bit [1:0] t, bit s, bit [10:0] a, bit lab);
			longint s0, s1;
			bit f0, f1;
			if (op == OP_TRAIN) begin
				// travel class zero and records past capacity are dropped
				if (t == 0 || n_cnt[0] + n_cnt[1] >= MAX_RECORDS) return;
				n_cnt[lab]++;
				trav_cnt[lab * 3 + t - 1]++;
				sex_cnt[lab * 2 + s]++;
				age_tot[lab] += a;
				age_sq_tot[lab] += 64'(a) * 64'(a);
				return;
			end
			if (!class_trained(0) || !class_trained(1)) begin
				verdicts.insert(verdicts.size(), 2'b01);
				return;
			end
			s0 = class_score(0, t, s, a, f0);
			s1 = class_score(1, t, s, a, f1);
			verdicts.insert(verdicts.size(), {f1 && (!f0 || s1 >= s0), 1'b0});
		endfunction

		function bit check_result(bit p, bit inc, output string msg);
			bit [1:0] e;
			if (verdicts.size() == 0) begin
				msg = $sformatf("unexpected result predicted=%0d incomplete=%0d", p, inc);
				return 0;
			end
			e = verdicts.pop_front();
			msg = "";
			if (p != e[1])
				msg = $sformatf("predicted %0d, expected %0d", p, e[1]);
			if (inc != e[0])
				msg = {msg, $sformatf(" incomplete %0d, expected %0d", inc, e[0])};
			return msg == "";
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic opcode = 0;
	logic [1:0] travel_class = 1;
	logic sex = 0;
	logic [AGE_W-1:0] age = 0;
	logic label = 0;
	logic out_valid;
	logic out_ready = 0;
	logic predicted;
	logic incomplete;

	nb_scoreboard sb = new();
	int mismatches = 0;
	int quiet_cycles = 0;
	bit no_gaps = 0;
	bit timed_out = 0;

	always #5 clk = ~clk;

	naive_bayes_classifier DUT (.*);

	task automatic report(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Drive one request and hold it until taken
	task automatic send(nbc_op_t op, bit [1:0] t, bit s, bit [10:0] a, bit lab);
		bit took;
		if (!no_gaps && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		in_valid     <= 1'b1;
		opcode       <= (op == OP_CLASSIFY);
		travel_class <= t;
		sex          <= s;
		age          <= a;
		label        <= lab;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		sb.note_request(op, t, s, a, lab);
	endtask

	task automatic send_random(int classify_pct);
		nbc_op_t op;
		bit [1:0] t;
		op = ($urandom_range(99) < classify_pct) ? OP_CLASSIFY : OP_TRAIN;
		t = ($urandom_range(99) < 5) ? 2'd0 : 2'($urandom_range(3, 1));
		send(op, t, 1'($urandom), 11'($urandom_range(2047)), 1'($urandom));
	endtask

	// Result sampling, back-pressure and watchdog
	initial begin
		bit took_out;
		bit p, inc;
		string msg;
		forever begin
			@(negedge clk);
			took_out = out_valid && out_ready;
			p = predicted;
			inc = incomplete;
			if ((in_valid && in_ready) || took_out) quiet_cycles = 0;
			else quiet_cycles++;
			@(posedge clk);
			if (took_out && !sb.check_result(p, inc, msg)) report(msg);
			out_ready <= no_gaps || $urandom_range(99) >= 14;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				timed_out = 1;
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty model, zero variance, extremes, dropped record
		send(OP_CLASSIFY, 2'd1, 1'b0, 11'd0, 1'b0);
		send(OP_TRAIN, 2'd1, 1'b0, 11'd100, 1'b0);
		send(OP_TRAIN, 2'd2, 1'b1, 11'd100, 1'b0);
		send(OP_TRAIN, 2'd3, 1'b1, 11'd0, 1'b1);
		send(OP_TRAIN, 2'd1, 1'b1, 11'd2047, 1'b1);
		send(OP_TRAIN, 2'd0, 1'b0, 11'd500, 1'b0);
		send(OP_CLASSIFY, 2'd2, 1'b1, 11'd100, 1'b1);
		send(OP_TRAIN, 2'd3, 1'b1, 11'd104, 1'b0);
		send(OP_CLASSIFY, 2'd1, 1'b0, 11'd0, 1'b0);
		send(OP_CLASSIFY, 2'd3, 1'b1, 11'd2047, 1'b0);
		send(OP_CLASSIFY, 2'd0, 1'b1, 11'd1000, 1'b1);
		send(OP_CLASSIFY, 2'd2, 1'b0, 11'd101, 1'b0);
		send(OP_CLASSIFY, 2'd1, 1'b1, 11'd1024, 1'b1);
		send(OP_TRAIN, 2'd2, 1'b0, 11'd2047, 1'b0);
		send(OP_CLASSIFY, 2'd2, 1'b0, 11'd1023, 1'b0);

		// hold off until the model has answered everything
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		// random mix, one stretch without gaps
		for (int i = 0; i < 250; i++) begin
			no_gaps = (i >= 150 && i < 230);
			send_random(12);
		end
		no_gaps = 0;
		// mostly training, then classify against a large model
		for (int i = 0; i < 450; i++) send_random(3);
		for (int i = 0; i < 85; i++) send_random(40);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && !timed_out)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
